// ===== src/enhs_pkg.sv =====
// Shared widths, constants, types and hash helpers of the ECMP next-hop selector.
package enhs_pkg;

   localparam int WORD_W      = 32;
   localparam int KEY_WORDS   = 3;
   localparam int PROTO_W     = 8;
   localparam int PORT_W      = 16;
   localparam int GROUP_W     = 3;
   localparam int COUNT_W     = 7;
   localparam int POS_W       = 6;
   localparam int QUEUE_W     = 3;
   localparam int CSR_INDEX_W = 1;

   localparam int MAX_NEXTHOPS = 64;
   localparam int NUM_QUEUES   = 8;

   // remainder unit: bits of the hash consumed per stage
   localparam int MOD_BITS   = 4;
   localparam int MOD_STAGES = WORD_W / MOD_BITS;

   localparam logic [WORD_W-1:0] MUR_C1     = 32'hcc9e2d51;
   localparam logic [WORD_W-1:0] MUR_C2     = 32'h1b873593;
   localparam logic [WORD_W-1:0] MUR_N      = 32'he6546b64;
   localparam logic [WORD_W-1:0] MUR_F1     = 32'h85ebca6b;
   localparam logic [WORD_W-1:0] MUR_F2     = 32'hc2b2ae35;
   localparam logic [WORD_W-1:0] MUR_KEY_LEN = 32'd12;

   localparam logic [PROTO_W-1:0] PROTO_TCP    = 8'h06;
   localparam logic [PROTO_W-1:0] PROTO_UDP    = 8'h11;
   localparam logic [PROTO_W-1:0] PROTO_ACK    = 8'hFC;
   localparam logic [PROTO_W-1:0] PROTO_NACK   = 8'hFD;
   localparam logic [PROTO_W-1:0] PROTO_QCN    = 8'hFE;
   localparam logic [PROTO_W-1:0] PROTO_PFC    = 8'hFF;

   localparam logic [QUEUE_W-1:0] QUEUE_TOP = 3'd0;
   localparam logic [QUEUE_W-1:0] QUEUE_TCP = 3'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_SEED     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_HIGH_PRIO = 1'b1;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_type;

   typedef struct packed {
      logic               no_route;
      logic [QUEUE_W-1:0] queue_index;
      logic [COUNT_W-1:0] divisor;
   } side_type;

   function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
      return {x[WORD_W-16:0], x[WORD_W-1:WORD_W-15]};
   endfunction

   // one body round of the hash state: xor, rotate by 13, times 5 plus constant
   function automatic logic [WORD_W-1:0] mix_state(input logic [WORD_W-1:0] h,
                                                   input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] x;
      x = h ^ k;
      x = {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
      return x + {x[WORD_W-3:0], 2'b00} + MUR_N;
   endfunction

endpackage

// ===== src/enhs_key_mix.sv =====
// Key word premix: multiply, rotate and multiply each flow key word in two stages.
module enhs_key_mix (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  enhs_pkg::key_type  in_key,
   input  enhs_pkg::side_type in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output enhs_pkg::key_type  out_key,
   output enhs_pkg::side_type out_side
);
   import enhs_pkg::*;

   logic     v1_ff, v2_ff;
   logic     en1, en2;
   key_type  ka_ff, ka_in;
   key_type  kb_ff, kb_in;
   side_type side1_ff, side2_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      for (int i = 0; i < KEY_WORDS; i++) begin
         ka_in[i] = in_key[i] * MUR_C1;
         kb_in[i] = rotl15(ka_ff[i]) * MUR_C2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         ka_ff    <= ka_in;
         side1_ff <= in_side;
      end
      if (en2 && v1_ff) begin
         kb_ff    <= kb_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_key   = kb_ff;
   assign out_side  = side2_ff;

endmodule

// ===== src/enhs_hash_fold.sv =====
// Hash state rounds and finalisation mix, six register stages.
module enhs_hash_fold (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [enhs_pkg::WORD_W-1:0] hash_seed,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  enhs_pkg::key_type           in_key,
   input  enhs_pkg::side_type          in_side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [enhs_pkg::WORD_W-1:0] out_hash,
   output enhs_pkg::side_type          out_side
);
   import enhs_pkg::*;

   localparam int FOLD_STAGES = 6;

   logic [FOLD_STAGES-1:0] v_ff;
   logic [FOLD_STAGES-1:0] en;
   side_type               side_ff [FOLD_STAGES];

   logic [WORD_W-1:0] h1_ff, k1_ff, k2a_ff;
   logic [WORD_W-1:0] h2_ff, k2b_ff;
   logic [WORD_W-1:0] f_ff, f_in, h3_in;
   logic [WORD_W-1:0] m1_ff;
   logic [WORD_W-1:0] m2_ff, g_in;
   logic [WORD_W-1:0] hash_ff;

   assign en[FOLD_STAGES-1] = !v_ff[FOLD_STAGES-1] || out_ready;
   for (genvar s = 0; s < FOLD_STAGES - 1; s++) begin : g_en
      assign en[s] = !v_ff[s] || en[s+1];
   end
   assign in_ready = en[0];

   always_comb begin
      h3_in = mix_state(h2_ff, k2b_ff);
      f_in  = h3_in ^ MUR_KEY_LEN;
      f_in  = f_in ^ (f_in >> 16);
      g_in  = m1_ff ^ (m1_ff >> 13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < FOLD_STAGES; s++) begin
            if (en[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0] && in_valid) begin
         h1_ff      <= mix_state(hash_seed, in_key[0]);
         k1_ff      <= in_key[1];
         k2a_ff     <= in_key[2];
         side_ff[0] <= in_side;
      end
      if (en[1] && v_ff[0]) begin
         h2_ff      <= mix_state(h1_ff, k1_ff);
         k2b_ff     <= k2a_ff;
         side_ff[1] <= side_ff[0];
      end
      if (en[2] && v_ff[1]) begin
         f_ff       <= f_in;
         side_ff[2] <= side_ff[1];
      end
      if (en[3] && v_ff[2]) begin
         m1_ff      <= f_ff * MUR_F1;
         side_ff[3] <= side_ff[2];
      end
      if (en[4] && v_ff[3]) begin
         m2_ff      <= g_in * MUR_F2;
         side_ff[4] <= side_ff[3];
      end
      if (en[5] && v_ff[4]) begin
         hash_ff    <= m2_ff ^ (m2_ff >> 16);
         side_ff[5] <= side_ff[4];
      end
   end

   assign out_valid = v_ff[FOLD_STAGES-1];
   assign out_hash  = hash_ff;
   assign out_side  = side_ff[FOLD_STAGES-1];

endmodule

// ===== src/enhs_mod_unit.sv =====
// Pipelined remainder of the hash by the next-hop count, four hash bits per stage.
module enhs_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [enhs_pkg::WORD_W-1:0] in_hash,
   input  enhs_pkg::side_type          in_side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [enhs_pkg::POS_W-1:0]  out_pos,
   output logic [enhs_pkg::WORD_W-1:0] out_hash,
   output enhs_pkg::side_type          out_side
);
   import enhs_pkg::*;

   localparam int LAST = MOD_STAGES - 1;

   logic [MOD_STAGES-1:0] v_ff;
   logic [MOD_STAGES-1:0] en;
   logic [MOD_STAGES-1:0] v_src;
   logic [COUNT_W-1:0]    rem_ff   [MOD_STAGES];
   logic [COUNT_W-1:0]    rem_src  [MOD_STAGES];
   logic [COUNT_W-1:0]    rem_in   [MOD_STAGES];
   logic [WORD_W-1:0]     hash_ff  [MOD_STAGES];
   logic [WORD_W-1:0]     hash_src [MOD_STAGES];
   side_type              side_ff  [MOD_STAGES];
   side_type              side_src [MOD_STAGES];

   assign en[LAST] = !v_ff[LAST] || out_ready;
   assign in_ready = en[0];

   for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_head
         assign v_src[s]    = in_valid;
         assign rem_src[s]  = '0;
         assign hash_src[s] = in_hash;
         assign side_src[s] = in_side;
      end else begin : g_body
         assign v_src[s]    = v_ff[s-1];
         assign rem_src[s]  = rem_ff[s-1];
         assign hash_src[s] = hash_ff[s-1];
         assign side_src[s] = side_ff[s-1];
      end

      if (s < LAST) begin : g_chain
         assign en[s] = !v_ff[s] || en[s+1];
      end
   end

   always_comb begin
      logic [COUNT_W-1:0]  r;
      logic [COUNT_W-1:0]  t;
      logic [MOD_BITS-1:0] b;
      for (int s = 0; s < MOD_STAGES; s++) begin
         r = rem_src[s];
         b = hash_src[s][WORD_W-1-MOD_BITS*s -: MOD_BITS];
         for (int j = 0; j < MOD_BITS; j++) begin
            t = {r[COUNT_W-2:0], b[MOD_BITS-1-j]};
            r = (t >= side_src[s].divisor) ? t - side_src[s].divisor : t;
         end
         rem_in[s] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < MOD_STAGES; s++) begin
            if (en[s]) v_ff[s] <= v_src[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < MOD_STAGES; s++) begin
         if (en[s] && v_src[s]) begin
            rem_ff[s]  <= rem_in[s];
            hash_ff[s] <= hash_src[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   assign out_valid = v_ff[LAST];
   assign out_pos   = rem_ff[LAST][POS_W-1:0];
   assign out_hash  = hash_ff[LAST];
   assign out_side  = side_ff[LAST];

`ifndef NO_ASSERTIONS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      v_ff[LAST] |-> (rem_ff[LAST] < side_ff[LAST].divisor))
      else $error("remainder not below next-hop count");

   a_no_route_zero: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST] && side_ff[LAST].no_route) |->
         (out_pos == '0 && side_ff[LAST].queue_index == QUEUE_TOP))
      else $error("dropped request carries a position or queue");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST] && !out_ready) |=> (v_ff[LAST] && $stable(rem_ff[LAST])
                                      && $stable(hash_ff[LAST])))
      else $error("blocked result changed");

   a_head_moves_when_free: assert property (@(posedge clock) disable iff (reset)
      !v_ff[LAST] |-> in_ready)
      else $error("unit blocks input with free output stage");
`endif

endmodule

// ===== src/ecmp_next_hop_select.sv =====
// ECMP next-hop and egress queue selector, top level.
//
// Takes one packet header request per cycle while req_stall is low and returns one
// result per request, in order, through two key premix stages, six hash stages
// (each 32x32 multiply is registered) and eight remainder stages that each resolve
// four hash bits against the next-hop count. Every stage holds its own valid bit,
// so a stall on the result side only blocks the input once all stages are full.
// The configuration port is always ready; the user must write it only while no
// request is in flight, and the block itself does not enforce this.
module ecmp_next_hop_select (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [enhs_pkg::WORD_W-1:0]       req_src_addr,
   input  logic [enhs_pkg::WORD_W-1:0]       req_dst_addr,
   input  logic [enhs_pkg::PROTO_W-1:0]      req_protocol,
   input  logic [enhs_pkg::PORT_W-1:0]       req_src_port,
   input  logic [enhs_pkg::PORT_W-1:0]       req_dst_port,
   input  logic [enhs_pkg::GROUP_W-1:0]      req_priority_group,
   input  logic [enhs_pkg::COUNT_W-1:0]      req_nexthop_count,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [enhs_pkg::POS_W-1:0]        rsp_nexthop_pos,
   output logic                              rsp_no_route,
   output logic [enhs_pkg::WORD_W-1:0]       rsp_hash_value,
   output logic [enhs_pkg::QUEUE_W-1:0]      rsp_queue_index,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [enhs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [enhs_pkg::WORD_W-1:0]       csr_data
);
   import enhs_pkg::*;

   logic [WORD_W-1:0] hash_seed_ff;
   logic              ack_high_prio_ff;

   logic              is_ack;
   logic [PORT_W*2-1:0] port_word;
   key_type           key_in;
   side_type          side_in;
   logic [COUNT_W-1:0] count_sat;

   logic              km_ready, km_valid;
   key_type           km_key;
   side_type          km_side;
   logic              hf_ready, hf_valid;
   logic [WORD_W-1:0] hf_hash;
   side_type          hf_side;
   logic              mu_ready;
   side_type          mu_side;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff     <= '0;
         ack_high_prio_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HASH_SEED:     hash_seed_ff     <= csr_data;
            CSR_ACK_HIGH_PRIO: ack_high_prio_ff <= csr_data[0];
            default:           hash_seed_ff     <= hash_seed_ff;
         endcase
      end
   end

   always_comb begin
      is_ack = (req_protocol == PROTO_ACK) || (req_protocol == PROTO_NACK);
      if ((req_protocol == PROTO_TCP) || (req_protocol == PROTO_UDP) || is_ack) begin
         port_word = {req_dst_port, req_src_port};
      end else begin
         port_word = '0;
      end
      key_in[0] = req_src_addr;
      key_in[1] = req_dst_addr;
      key_in[2] = port_word;

      count_sat = (32'(req_nexthop_count) > MAX_NEXTHOPS) ?
                  COUNT_W'(MAX_NEXTHOPS) : req_nexthop_count;

      if (count_sat == '0) begin
         side_in.no_route    = 1'b1;
         side_in.queue_index = QUEUE_TOP;
         side_in.divisor     = COUNT_W'(1);
      end else begin
         side_in.no_route = 1'b0;
         side_in.divisor  = count_sat;
         priority if ((req_protocol == PROTO_PFC) || (req_protocol == PROTO_QCN)
                      || (ack_high_prio_ff && is_ack)) begin
            side_in.queue_index = QUEUE_TOP;
         end else if (req_protocol == PROTO_TCP) begin
            side_in.queue_index = QUEUE_TCP;
         end else if (32'(req_priority_group) >= NUM_QUEUES) begin
            side_in.queue_index = QUEUE_W'(NUM_QUEUES - 1);
         end else begin
            side_in.queue_index = req_priority_group;
         end
      end
   end

   assign req_stall = !km_ready;

   enhs_key_mix u_key_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (km_ready),
      .in_key    (key_in),
      .in_side   (side_in),
      .out_valid (km_valid),
      .out_ready (hf_ready),
      .out_key   (km_key),
      .out_side  (km_side)
   );

   enhs_hash_fold u_hash_fold (
      .clock     (clock),
      .reset     (reset),
      .hash_seed (hash_seed_ff),
      .in_valid  (km_valid),
      .in_ready  (hf_ready),
      .in_key    (km_key),
      .in_side   (km_side),
      .out_valid (hf_valid),
      .out_ready (mu_ready),
      .out_hash  (hf_hash),
      .out_side  (hf_side)
   );

   enhs_mod_unit u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hf_valid),
      .in_ready  (mu_ready),
      .in_hash   (hf_hash),
      .in_side   (hf_side),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_pos   (rsp_nexthop_pos),
      .out_hash  (rsp_hash_value),
      .out_side  (mu_side)
   );

   assign rsp_no_route    = mu_side.no_route;
   assign rsp_queue_index = mu_side.queue_index;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the ECMP next-hop selector: directed headers, then random traffic.
`timescale 1ns / 100ps

module tb_top;
   import enhs_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 250;
   localparam int REPORT_LIMIT = 10;
   localparam int NUM_ROWS     = 20;

   // protocols outside the handled set
   localparam logic [PROTO_W-1:0] PROTO_HOPOPT     = 8'h00;
   localparam logic [PROTO_W-1:0] PROTO_ICMP       = 8'h01;
   localparam logic [PROTO_W-1:0] PROTO_CBT        = 8'h07;
   localparam logic [PROTO_W-1:0] PROTO_CHAOS      = 8'h10;
   localparam logic [PROTO_W-1:0] PROTO_MUX        = 8'h12;
   localparam logic [PROTO_W-1:0] PROTO_UNASSIGNED = 8'hFB;

   // which expected fields a directed row gives outright: position, no route, queue
   localparam logic [2:0] KNOWN_ALL         = 3'b111;
   localparam logic [2:0] KNOWN_ROUTE_QUEUE = 3'b011;

   typedef struct packed {
      logic [WORD_W-1:0]  src_addr;
      logic [WORD_W-1:0]  dst_addr;
      logic [PROTO_W-1:0] protocol;
      logic [PORT_W-1:0]  src_port;
      logic [PORT_W-1:0]  dst_port;
      logic [GROUP_W-1:0] priority_group;
      logic [COUNT_W-1:0] nexthop_count;
   } packet_header_type;

   typedef struct packed {
      logic [POS_W-1:0]   nexthop_pos;
      logic               no_route;
      logic [WORD_W-1:0]  hash_value;
      logic [QUEUE_W-1:0] queue_index;
   } route_choice_type;

   typedef struct packed {
      packet_header_type  header;
      logic [2:0]         known;
      logic [POS_W-1:0]   nexthop_pos;
      logic               no_route;
      logic [QUEUE_W-1:0] queue_index;
   } stimulus_row_type;

   localparam stimulus_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{'{32'h00000000, 32'h00000000, PROTO_HOPOPT, 16'h0000, 16'h0000, 3'd0, 7'd0},
        KNOWN_ALL, 6'd0, 1'b1, QUEUE_TOP},
      '{'{32'hFFFFFFFF, 32'hFFFFFFFF, PROTO_PFC, 16'hFFFF, 16'hFFFF, 3'd7, 7'd127},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, QUEUE_TOP},
      '{'{32'h12345678, 32'h9ABCDEF0, PROTO_TCP, 16'h1234, 16'h5678, 3'd5, 7'd1},
        KNOWN_ALL, 6'd0, 1'b0, QUEUE_TCP},
      '{'{32'hFFFFFFFF, 32'h00000000, PROTO_UDP, 16'hFFFF, 16'h0000, 3'd7, 7'd64},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd7},
      '{'{32'h00000000, 32'hFFFFFFFF, PROTO_UDP, 16'h0000, 16'hFFFF, 3'd0, 7'd3},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd0},
      '{'{32'hC0A80001, 32'h0A000001, PROTO_ACK, 16'h12B7, 16'h0400, 3'd3, 7'd8},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd3},
      '{'{32'h0A000002, 32'hC0A80002, PROTO_NACK, 16'h0400, 16'h12B7, 3'd6, 7'd63},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd6},
      '{'{32'h01020304, 32'h05060708, PROTO_QCN, 16'hBEEF, 16'hCAFE, 3'd5, 7'd5},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, QUEUE_TOP},
      '{'{32'hDEADBEEF, 32'hFEEDFACE, PROTO_PFC, 16'h0001, 16'h8000, 3'd2, 7'd64},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, QUEUE_TOP},
      '{'{32'h00000000, 32'h00000000, PROTO_HOPOPT, 16'hABCD, 16'h1234, 3'd4, 7'd7},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd4},
      '{'{32'h0A0B0C0D, 32'h11223344, PROTO_ICMP, 16'hFFFF, 16'hFFFF, 3'd1, 7'd65},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd1},
      '{'{32'h80000000, 32'h00000001, PROTO_CBT, 16'h0050, 16'h01BB, 3'd2, 7'd2},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd2},
      '{'{32'h00000001, 32'h80000000, PROTO_CHAOS, 16'h1111, 16'h2222, 3'd3, 7'd17},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd3},
      '{'{32'h7FFFFFFF, 32'hFFFFFFFE, PROTO_MUX, 16'h3333, 16'h4444, 3'd4, 7'd100},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd4},
      '{'{32'h0F0F0F0F, 32'hF0F0F0F0, PROTO_UNASSIGNED, 16'h5555, 16'hAAAA, 3'd5, 7'd33},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd5},
      '{'{32'h11111111, 32'h22222222, PROTO_TCP, 16'hFFFF, 16'hFFFF, 3'd7, 7'd0},
        KNOWN_ALL, 6'd0, 1'b1, QUEUE_TOP},
      '{'{32'h33333333, 32'h44444444, PROTO_ACK, 16'h8000, 16'h0001, 3'd6, 7'd0},
        KNOWN_ALL, 6'd0, 1'b1, QUEUE_TOP},
      '{'{32'hAAAAAAAA, 32'h55555555, PROTO_UDP, 16'h5555, 16'hAAAA, 3'd7, 7'd1},
        KNOWN_ALL, 6'd0, 1'b0, 3'd7},
      '{'{32'hC0000000, 32'h00000003, PROTO_TCP, 16'h7FFF, 16'h8001, 3'd0, 7'd64},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, QUEUE_TCP},
      '{'{32'hFFFFFFFF, 32'hFFFFFFFF, PROTO_UDP, 16'hFFFF, 16'hFFFF, 3'd7, 7'd127},
        KNOWN_ROUTE_QUEUE, 6'd0, 1'b0, 3'd7}
   };

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [WORD_W-1:0]      req_src_addr       = '0;
   logic [WORD_W-1:0]      req_dst_addr       = '0;
   logic [PROTO_W-1:0]     req_protocol       = '0;
   logic [PORT_W-1:0]      req_src_port       = '0;
   logic [PORT_W-1:0]      req_dst_port       = '0;
   logic [GROUP_W-1:0]     req_priority_group = '0;
   logic [COUNT_W-1:0]     req_nexthop_count  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [POS_W-1:0]       rsp_nexthop_pos;
   logic                   rsp_no_route;
   logic [WORD_W-1:0]      rsp_hash_value;
   logic [QUEUE_W-1:0]     rsp_queue_index;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [WORD_W-1:0]      csr_data           = '0;

   logic [WORD_W-1:0] cfg_hash_seed     = '0;
   logic              cfg_ack_high_prio = 1'b0;

   route_choice_type expected_choices [$];
   int            send_idle_pct   = 22;
   int            rsp_stall_pct   = 62;
   int            cycle_count     = 0;
   int            requests_sent   = 0;
   int            results_checked = 0;
   int            mismatch_count  = 0;

   ecmp_next_hop_select i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_src_addr       (req_src_addr),
      .req_dst_addr       (req_dst_addr),
      .req_protocol       (req_protocol),
      .req_src_port       (req_src_port),
      .req_dst_port       (req_dst_port),
      .req_priority_group (req_priority_group),
      .req_nexthop_count  (req_nexthop_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_nexthop_pos    (rsp_nexthop_pos),
      .rsp_no_route       (rsp_no_route),
      .rsp_hash_value     (rsp_hash_value),
      .rsp_queue_index    (rsp_queue_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] x,
                                                     input int unsigned r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

   function automatic logic [WORD_W-1:0] absorb_key_word(input logic [WORD_W-1:0] h,
                                                         input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] m;
      m = k * MUR_C1;
      m = rotate_left(m, 15);
      m = m * MUR_C2;
      h = rotate_left(h ^ m, 13);
      return h * 32'd5 + MUR_N;
   endfunction

   function automatic logic [WORD_W-1:0] flow_key_hash(input logic [WORD_W-1:0] src,
                                                       input logic [WORD_W-1:0] dst,
                                                       input logic [WORD_W-1:0] ports,
                                                       input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] h;
      h = absorb_key_word(seed, src);
      h = absorb_key_word(h, dst);
      h = absorb_key_word(h, ports);
      h = h ^ MUR_KEY_LEN;
      h = h ^ (h >> 16);
      h = h * MUR_F1;
      h = h ^ (h >> 13);
      h = h * MUR_F2;
      return h ^ (h >> 16);
   endfunction

   function automatic route_choice_type select_route(input packet_header_type hdr);
      route_choice_type  choice;
      logic [WORD_W-1:0] ports;
      logic              ack_like;
      int unsigned       count;
      ack_like = (hdr.protocol == PROTO_ACK) || (hdr.protocol == PROTO_NACK);
      ports = '0;
      if (hdr.protocol == PROTO_TCP || hdr.protocol == PROTO_UDP || ack_like) begin
         ports = {hdr.dst_port, hdr.src_port};
      end
      choice = '0;
      choice.hash_value = flow_key_hash(hdr.src_addr, hdr.dst_addr, ports, cfg_hash_seed);
      count = hdr.nexthop_count;
      if (count > MAX_NEXTHOPS) begin
         count = MAX_NEXTHOPS;
      end
      if (count == 0) begin
         choice.no_route = 1'b1;
      end else begin
         choice.nexthop_pos = POS_W'(choice.hash_value % count);
         if (hdr.protocol == PROTO_PFC || hdr.protocol == PROTO_QCN ||
             (cfg_ack_high_prio && ack_like)) begin
            choice.queue_index = QUEUE_TOP;
         end else if (hdr.protocol == PROTO_TCP) begin
            choice.queue_index = QUEUE_TCP;
         end else if (int'(hdr.priority_group) >= NUM_QUEUES) begin
            choice.queue_index = QUEUE_W'(NUM_QUEUES - 1);
         end else begin
            choice.queue_index = hdr.priority_group;
         end
      end
      return choice;
   endfunction

   task automatic send_request(input packet_header_type hdr, input route_choice_type choice);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_src_addr       <= hdr.src_addr;
      req_dst_addr       <= hdr.dst_addr;
      req_protocol       <= hdr.protocol;
      req_src_port       <= hdr.src_port;
      req_dst_port       <= hdr.dst_port;
      req_priority_group <= hdr.priority_group;
      req_nexthop_count  <= hdr.nexthop_count;
      do @(posedge clock); while (req_stall);
      expected_choices.insert(expected_choices.size(), choice);
      requests_sent++;
   endtask

   // hold the sender until every result is back and the pipeline is empty
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_choices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_HASH_SEED) begin
         cfg_hash_seed = data;
      end else begin
         cfg_ack_high_prio = data[0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_choices.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      route_choice_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_choices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("tb_top: result with nothing expected: %s %0d %0b %08h %0d",
                        "pos/no_route/hash/queue", rsp_nexthop_pos, rsp_no_route,
                        rsp_hash_value, rsp_queue_index);
            end
         end else begin
            want = expected_choices.pop_front();
            results_checked++;
            if (rsp_nexthop_pos !== want.nexthop_pos || rsp_no_route !== want.no_route ||
                rsp_hash_value !== want.hash_value || rsp_queue_index !== want.queue_index) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("tb_top: mismatch on result %0d", results_checked);
                  $display("   expected pos %0d no_route %0b hash %08h queue %0d",
                           want.nexthop_pos, want.no_route, want.hash_value, want.queue_index);
                  $display("   actual   pos %0d no_route %0b hash %08h queue %0d",
                           rsp_nexthop_pos, rsp_no_route, rsp_hash_value, rsp_queue_index);
               end
            end
         end
      end
   end

   initial begin
      packet_header_type hdr;
      route_choice_type  choice;
      stimulus_row_type  row;
      logic [WORD_W-1:0] seed;
      int pick;
      int leftover;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         row    = DIRECTED_ROWS[i];
         choice = select_route(row.header);
         if (row.known[2]) choice.nexthop_pos = row.nexthop_pos;
         if (row.known[1]) choice.no_route    = row.no_route;
         if (row.known[0]) choice.queue_index = row.queue_index;
         send_request(row.header, choice);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0:       seed = 32'hFFFFFFFF;
            3:       seed = 32'h00000000;
            4:       seed = 32'h80000000;
            default: seed = $urandom();
         endcase
         write_register(CSR_HASH_SEED, seed);
         write_register(CSR_ACK_HIGH_PRIO, {31'($urandom()), 1'(phase % 2)});
         send_idle_pct = (phase / 2 == 0) ? 22 : (phase / 2 == 1) ? 62 : 0;
         rsp_stall_pct = (phase / 2 == 0) ? 62 : (phase / 2 == 1) ? 22 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               wait_drained();
            end
            hdr.src_addr = $urandom();
            hdr.dst_addr = $urandom();
            pick = $urandom_range(99);
            if (pick < 5) begin
               hdr.src_addr = '0;
            end else if (pick < 10) begin
               hdr.dst_addr = '1;
            end
            if ($urandom_range(99) < 80) begin
               case ($urandom_range(5))
                  0:       hdr.protocol = PROTO_TCP;
                  1:       hdr.protocol = PROTO_UDP;
                  2:       hdr.protocol = PROTO_ACK;
                  3:       hdr.protocol = PROTO_NACK;
                  4:       hdr.protocol = PROTO_QCN;
                  default: hdr.protocol = PROTO_PFC;
               endcase
            end else begin
               hdr.protocol = PROTO_W'($urandom_range(255));
            end
            hdr.src_port       = PORT_W'($urandom());
            hdr.dst_port       = PORT_W'($urandom());
            hdr.priority_group = GROUP_W'($urandom());
            pick = $urandom_range(99);
            if (pick < 5) begin
               hdr.nexthop_count = '0;
            end else if (pick < 10) begin
               hdr.nexthop_count = COUNT_W'($urandom_range(127, MAX_NEXTHOPS + 1));
            end else if (pick < 30) begin
               hdr.nexthop_count = COUNT_W'($urandom_range(4, 1));
            end else begin
               hdr.nexthop_count = COUNT_W'($urandom_range(MAX_NEXTHOPS, 1));
            end
            send_request(hdr, select_route(hdr));
         end
      end

      wait_drained();
      leftover = expected_choices.size();
      $display("tb_top: %0d requests sent, %0d results checked, %0d mismatches",
               requests_sent, results_checked, mismatch_count);
      $display("tb_top: %0d seed settings, ACK priority off and on, under three idle mixes",
               NUM_PHASES + 1);
      if (mismatch_count == 0 && leftover == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/enhs_pkg.sv
src/enhs_key_mix.sv
src/enhs_hash_fold.sv
src/enhs_mod_unit.sv
src/ecmp_next_hop_select.sv
tb/tb_top.sv
